[rtl/tsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared widths, register indexes and pipeline types of the trapezoidal
// shaping filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DECAY_W    = 16;
  localparam int LEN_W      = 10;
  localparam int DLY_W      = 12;
  localparam int COUNT_W    = 13;
  localparam int DIFF_W     = 18;
  localparam int RAMP_W     = 32;
  localparam int PROD_W     = DECAY_W + 1 + DIFF_W;
  localparam int SHAPE_W    = 48;
  localparam int NUM_TAPS   = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CREDIT_W   = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  typedef enum logic [1:0] {
    REG_DECAY = 2'd0,
    REG_RISE  = 2'd1,
    REG_FLAT  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic start;
  } pipe_ctl_t;

  typedef struct packed {
    logic use_now;
    logic use_mem;
  } tap_sel_t;

endpackage

[rtl/tsf_tap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_tap_ram
// Sample history memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tsf_tap_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/tsf_history.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_history
// Sample history with three delay taps and the difference term
// d = x[n] - x[n-k] - x[n-k-m] + x[n-2k-m], two register stages.
// ----------------------------------------------------------------------------
module tsf_history #(
  parameter int DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [tsf_pkg::SAMPLE_W-1:0] sample,
  input  logic                               start_req,
  input  logic [tsf_pkg::LEN_W-1:0]          rise,
  input  logic [tsf_pkg::LEN_W-1:0]          flat,
  output tsf_pkg::pipe_ctl_t                 ctl,
  output logic signed [tsf_pkg::DIFF_W-1:0]  diff
);
  import tsf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = ((AW > DLY_W) ? AW : DLY_W) + 1;

  logic [AW-1:0]       wptr;
  logic [AW-1:0]       wptr_next;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [COUNT_W-1:0]  count_eff;
  logic [LEN_W:0]      len;
  logic [DLY_W-1:0]    dly [NUM_TAPS];
  tap_sel_t            sel [NUM_TAPS];
  tap_sel_t            sel1 [NUM_TAPS];
  logic [SAMPLE_W-1:0] tap_q [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] tap_val [NUM_TAPS];
  pipe_ctl_t           ctl1;
  logic signed [SAMPLE_W-1:0] x1;
  logic signed [DIFF_W-1:0]   diff_next;

  // a fresh waveform sees no earlier samples
  assign count_eff = start_req ? '0 : count;
  assign len       = {1'b0, rise} + {1'b0, flat};
  assign dly[0]    = {2'b00, rise};
  assign dly[1]    = {1'b0, len};
  assign dly[2]    = {2'b00, rise} + {1'b0, len};

  assign wptr_next  = (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign count_next = (count_eff < COUNT_MAX) ? count_eff + 1'b1 : count_eff;

  for (genvar i = 0; i < NUM_TAPS; i++) begin : g_tap
    logic [CW-1:0] wide_ptr;
    logic [CW-1:0] wide_dly;
    logic [CW-1:0] wide_addr;

    assign wide_ptr  = CW'(wptr);
    assign wide_dly  = CW'(dly[i]);
    assign wide_addr = (wide_ptr >= wide_dly) ? wide_ptr - wide_dly
                                              : wide_ptr + CW'(DEPTH) - wide_dly;

    assign sel[i].use_now = (dly[i] == '0);
    assign sel[i].use_mem = (dly[i] != '0) && ({1'b0, dly[i]} <= count_eff)
                            && (wide_dly < CW'(DEPTH));

    tsf_tap_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (SAMPLE_W)
    ) u_ram (
      .clk     (clk),
      .wr_en   (in_valid),
      .wr_addr (wptr),
      .wr_data (sample),
      .rd_addr (wide_addr[AW-1:0]),
      .rd_data (tap_q[i])
    );

    assign tap_val[i] = sel1[i].use_mem ? $signed(tap_q[i]) :
                        sel1[i].use_now ? x1 : '0;
  end

  assign diff_next = DIFF_W'(x1) - DIFF_W'(tap_val[0]) - DIFF_W'(tap_val[1])
                   + DIFF_W'(tap_val[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      count     <= '0;
      ctl1      <= '0;
      ctl       <= '0;
    end else begin
      if (in_valid) begin
        wptr  <= wptr_next;
        count <= count_next;
      end
      ctl1 <= '{valid: in_valid, start: start_req};
      ctl  <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= sample;
    sel1 <= sel;
    diff <= diff_next;
  end

endmodule

[rtl/tsf_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_accum
// Ramp accumulator q += d with the decay product M*d, then the shaping
// accumulator s += q + M*d.
// ----------------------------------------------------------------------------
module tsf_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  tsf_pkg::pipe_ctl_t                 ctl_in,
  input  logic signed [tsf_pkg::DIFF_W-1:0]  diff,
  input  logic [tsf_pkg::DECAY_W-1:0]        decay,
  output logic                               push,
  output logic signed [tsf_pkg::SHAPE_W-1:0] result
);
  import tsf_pkg::*;

  pipe_ctl_t                 ctl3;
  logic signed [RAMP_W-1:0]  ramp;
  logic signed [RAMP_W-1:0]  ramp_next;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [SHAPE_W-1:0] shape;
  logic signed [SHAPE_W-1:0] shape_next;

  assign ramp_next  = (ctl_in.start ? RAMP_W'(0) : ramp) + RAMP_W'(diff);
  assign prod_next  = $signed({1'b0, decay}) * diff;
  assign shape_next = (ctl3.start ? SHAPE_W'(0) : shape) + SHAPE_W'(ramp)
                    + SHAPE_W'(prod);

  assign push   = ctl3.valid;
  assign result = shape_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3  <= '0;
      ramp  <= '0;
      shape <= '0;
    end else begin
      ctl3 <= ctl_in;
      if (ctl_in.valid) begin
        ramp <= ramp_next;
      end
      if (ctl3.valid) begin
        shape <= shape_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.valid) begin
      prod <= prod_next;
    end
  end

endmodule

[rtl/tsf_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_out_fifo
// Small result queue that absorbs the words in flight while the sink stalls.
// ----------------------------------------------------------------------------
module tsf_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [tsf_pkg::SHAPE_W-1:0]   push_data,
  input  logic                          pop,
  output logic                          valid,
  output logic [tsf_pkg::SHAPE_W-1:0]   data
);
  import tsf_pkg::*;

  logic [SHAPE_W-1:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [CREDIT_W-1:0] count;

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CREDIT_W'(push) - CREDIT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/trapezoidal_shaping_filter_unit.sv]
`timescale 1ns / 1ps
// a result word passes the history registers, the accumulator and the result queue
// throughput: one sample per cycle; s_tready drops only when 8 samples are
// accepted whose results the sink has not yet taken (size of the result queue)
// reset clears the accumulators, sample count, write pointer and credit counts;
// the history memory is not cleared, taps older than the waveform read as zero
// ----------------------------------------------------------------------------
// trapezoidal_shaping_filter_unit
// Trapezoidal pulse shaper: delay taps, ramp and shaping accumulators,
// result queue and register port.
// ----------------------------------------------------------------------------
module trapezoidal_shaping_filter_unit #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tsf_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
  input  logic                          s_tuser,   // [0] start_req
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tsf_pkg::SHAPE_W-1:0]   m_tdata,   // [47:0] shaped
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsf_pkg::ADDR_W-1:0]    paddr,
  input  logic [tsf_pkg::DATA_W-1:0]    pwdata,
  output logic [tsf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import tsf_pkg::*;

  logic [DECAY_W-1:0]  decay;
  logic [LEN_W-1:0]    rise;
  logic [LEN_W-1:0]    flat;
  logic [CREDIT_W-1:0] inflight;
  logic                in_acc;
  logic                out_acc;
  logic                cfg_wr;
  reg_idx_t            reg_idx;
  pipe_ctl_t           diff_ctl;
  logic signed [DIFF_W-1:0]  diff;
  logic                push;
  logic signed [SHAPE_W-1:0] result;

  assign pready   = 1'b1;
  assign reg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr   = psel & penable & pwrite & pready;

  // credit count covers words in the pipeline and in the result queue
  assign s_tready = (inflight < CREDIT_W'(FIFO_DEPTH));
  assign in_acc   = s_tvalid & s_tready;
  assign out_acc  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay    <= DECAY_W'(1);
      rise     <= LEN_W'(1);
      flat     <= '0;
      inflight <= '0;
    end else begin
      inflight <= inflight + CREDIT_W'(in_acc) - CREDIT_W'(out_acc);
      if (cfg_wr) begin
        case (reg_idx)
          REG_DECAY: decay <= pwdata[DECAY_W-1:0];
          REG_RISE:  rise  <= pwdata[LEN_W-1:0];
          REG_FLAT:  flat  <= pwdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DECAY: prdata = DATA_W'(decay);
      REG_RISE:  prdata = DATA_W'(rise);
      REG_FLAT:  prdata = DATA_W'(flat);
      default:   prdata = '0;
    endcase
  end

  tsf_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_acc),
    .sample    ($signed(s_tdata)),
    .start_req (s_tuser),
    .rise      (rise),
    .flat      (flat),
    .ctl       (diff_ctl),
    .diff      (diff)
  );

  tsf_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (diff_ctl),
    .diff   (diff),
    .decay  (decay),
    .push   (push),
    .result (result)
  );

  tsf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (out_acc),
    .valid     (m_tvalid),
    .data      (m_tdata)
  );

endmodule
